### src/segx_pkg.sv
`default_nettype none
package segx_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int TOL_WIDTH = 32;

    typedef enum logic [1:0] {
        ST_CROSS   = 2'd0,
        ST_OVERLAP = 2'd1,
        ST_MISS    = 2'd2
    } t_status;

    typedef struct packed {
        logic    valid;
        t_status status;
        logic    neg_x;
        logic    neg_y;
    } t_ctrl;

    localparam t_ctrl CTRL_IDLE = '{valid: 1'b0, status: ST_MISS, neg_x: 1'b0, neg_y: 1'b0};

endpackage
`default_nettype wire

### src/segment_intersection_core.sv
// Segment intersection core. One pair of segments is taken on every clock cycle and busy never
// rises, so start may be held high continuously. Each beat produces exactly one result on
// o_valid after passing the cross-product stages, the decision stages, the quotient pipeline,
// which retires one quotient bit per stage, and the output register. The receiver has no way
// to stall, so every result must be captured in the cycle it is shown.
// The tolerance register may only be written while no beat is in flight.
`default_nettype none
module segment_intersection_core #(
    parameter int COORD_WIDTH = segx_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic signed [COORD_WIDTH-1:0]   i_ax_start,
    input  wire logic signed [COORD_WIDTH-1:0]   i_ay_start,
    input  wire logic signed [COORD_WIDTH-1:0]   i_ax_end,
    input  wire logic signed [COORD_WIDTH-1:0]   i_ay_end,
    input  wire logic signed [COORD_WIDTH-1:0]   i_bx_start,
    input  wire logic signed [COORD_WIDTH-1:0]   i_by_start,
    input  wire logic signed [COORD_WIDTH-1:0]   i_bx_end,
    input  wire logic signed [COORD_WIDTH-1:0]   i_by_end,
    input  wire logic                            i_tol_we,
    input  wire logic [segx_pkg::TOL_WIDTH-1:0]  i_tol_data,
    output logic                                 o_valid,
    output segx_pkg::t_status                    o_status,
    output logic signed [COORD_WIDTH-1:0]        o_cross_x,
    output logic signed [COORD_WIDTH-1:0]        o_cross_y
);
    import segx_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int DW  = W + 1;
    localparam int CW  = 2 * DW + 1;
    localparam int PD  = CW + W;
    localparam int LAT = W + 7;

    logic [TOL_WIDTH-1:0] r_zero_tol;

    logic                 x_valid;
    logic signed [CW-1:0] x_den, x_na, x_nb;
    logic signed [DW-1:0] x_dx1, x_dy1;
    logic [4*W-1:0]       x_pass;

    t_ctrl         s_ctrl [0:W];
    logic [CW-1:0] s_den  [0:W];
    logic [PD-1:0] s_rem_x [0:W];
    logic [PD-1:0] s_rem_y [0:W];
    logic [W-1:0]  s_quo_x [0:W];
    logic [W-1:0]  s_quo_y [0:W];
    logic [4*W-1:0] s_pass [0:W];

    t_ctrl        f_ctrl;
    logic [W-1:0] f_x1, f_y1, f_mx, f_my, n_off_x, n_off_y, n_x, n_y;
    logic         r_valid;
    t_status      r_status;
    logic [W-1:0] r_x, r_y;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_tol <= TOL_WIDTH'(1);
        end else if (i_tol_we) begin
            r_zero_tol <= i_tol_data;
        end
    end

    segx_xprod #(.COORD_WIDTH(COORD_WIDTH)) u_xprod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (start && !busy),
        .i_ax_start (i_ax_start),
        .i_ay_start (i_ay_start),
        .i_ax_end   (i_ax_end),
        .i_ay_end   (i_ay_end),
        .i_bx_start (i_bx_start),
        .i_by_start (i_by_start),
        .i_bx_end   (i_bx_end),
        .i_by_end   (i_by_end),
        .o_valid    (x_valid),
        .o_den      (x_den),
        .o_na       (x_na),
        .o_nb       (x_nb),
        .o_dx1      (x_dx1),
        .o_dy1      (x_dy1),
        .o_pass     (x_pass)
    );

    segx_decide #(.COORD_WIDTH(COORD_WIDTH)) u_decide (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (x_valid),
        .i_den     (x_den),
        .i_na      (x_na),
        .i_nb      (x_nb),
        .i_dx1     (x_dx1),
        .i_dy1     (x_dy1),
        .i_pass    (x_pass),
        .i_tol     (r_zero_tol),
        .o_ctrl    (s_ctrl[0]),
        .o_den_mag (s_den[0]),
        .o_prod_x  (s_rem_x[0]),
        .o_prod_y  (s_rem_y[0]),
        .o_pass    (s_pass[0])
    );

    assign s_quo_x[0] = '0;
    assign s_quo_y[0] = '0;

    for (genvar k = 0; k < W; k++) begin : g_div
        segx_div_step #(.COORD_WIDTH(COORD_WIDTH), .STEP_BIT(W - 1 - k)) u_step (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (s_ctrl[k]),
            .i_den_mag (s_den[k]),
            .i_rem_x   (s_rem_x[k]),
            .i_rem_y   (s_rem_y[k]),
            .i_quo_x   (s_quo_x[k]),
            .i_quo_y   (s_quo_y[k]),
            .i_pass    (s_pass[k]),
            .o_ctrl    (s_ctrl[k+1]),
            .o_den_mag (s_den[k+1]),
            .o_rem_x   (s_rem_x[k+1]),
            .o_rem_y   (s_rem_y[k+1]),
            .o_quo_x   (s_quo_x[k+1]),
            .o_quo_y   (s_quo_y[k+1]),
            .o_pass    (s_pass[k+1])
        );
    end

    assign f_ctrl  = s_ctrl[W];
    assign f_x1    = s_pass[W][W-1:0];
    assign f_y1    = s_pass[W][2*W-1:W];
    assign f_mx    = s_pass[W][3*W-1:2*W];
    assign f_my    = s_pass[W][4*W-1:3*W];
    assign n_off_x = f_ctrl.neg_x ? (-s_quo_x[W]) : s_quo_x[W];
    assign n_off_y = f_ctrl.neg_y ? (-s_quo_y[W]) : s_quo_y[W];

    always_comb begin
        case (f_ctrl.status)
            ST_CROSS: begin
                n_x = f_x1 + n_off_x;
                n_y = f_y1 + n_off_y;
            end
            ST_OVERLAP: begin
                n_x = f_mx;
                n_y = f_my;
            end
            default: begin
                n_x = '0;
                n_y = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= f_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= f_ctrl.status;
        r_x      <= n_x;
        r_y      <= n_y;
    end

    assign o_valid   = r_valid;
    assign o_status  = r_status;
    assign o_cross_x = $signed(r_x);
    assign o_cross_y = $signed(r_y);

`ifndef NO_ASSERTIONS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LAT o_valid)
        else $error("accepted beat did not produce a result on time");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_MISS) |-> (o_cross_x == '0 && o_cross_y == '0))
        else $error("non-crossing result carries a nonzero point");

    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe survived reset");
`endif

endmodule
`default_nettype wire

### src/segx_xprod.sv
`default_nettype none
module segx_xprod #(
    parameter int COORD_WIDTH = segx_pkg::COORD_WIDTH_DEF,
    localparam int DW = COORD_WIDTH + 1,
    localparam int PW = 2 * DW,
    localparam int CW = PW + 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic signed [COORD_WIDTH-1:0] i_ax_start,
    input  wire logic signed [COORD_WIDTH-1:0] i_ay_start,
    input  wire logic signed [COORD_WIDTH-1:0] i_ax_end,
    input  wire logic signed [COORD_WIDTH-1:0] i_ay_end,
    input  wire logic signed [COORD_WIDTH-1:0] i_bx_start,
    input  wire logic signed [COORD_WIDTH-1:0] i_by_start,
    input  wire logic signed [COORD_WIDTH-1:0] i_bx_end,
    input  wire logic signed [COORD_WIDTH-1:0] i_by_end,
    output logic                               o_valid,
    output logic signed [CW-1:0]               o_den,
    output logic signed [CW-1:0]               o_na,
    output logic signed [CW-1:0]               o_nb,
    output logic signed [DW-1:0]               o_dx1,
    output logic signed [DW-1:0]               o_dy1,
    output logic [4*COORD_WIDTH-1:0]           o_pass
);
    import segx_pkg::*;

    localparam int W = COORD_WIDTH;

    logic signed [DW-1:0] n_dx1, n_dy1, n_dx2, n_dy2, n_ex, n_ey, n_msum;
    logic [4*W-1:0]       n_pass;

    logic [2:0]           r_valid;
    logic signed [DW-1:0] r_dx1, r_dy1, r_dx2, r_dy2, r_ex, r_ey;
    logic signed [DW-1:0] r2_dx1, r2_dy1, r3_dx1, r3_dy1;
    logic signed [PW-1:0] r_pd1, r_pd2, r_pa1, r_pa2, r_pb1, r_pb2;
    logic signed [CW-1:0] r_den, r_na, r_nb;
    logic [4*W-1:0]       r1_pass, r2_pass, r3_pass;

    assign n_dx1 = $signed({i_ax_end[W-1], i_ax_end}) - $signed({i_ax_start[W-1], i_ax_start});
    assign n_dy1 = $signed({i_ay_end[W-1], i_ay_end}) - $signed({i_ay_start[W-1], i_ay_start});
    assign n_dx2 = $signed({i_bx_end[W-1], i_bx_end}) - $signed({i_bx_start[W-1], i_bx_start});
    assign n_dy2 = $signed({i_by_end[W-1], i_by_end}) - $signed({i_by_start[W-1], i_by_start});
    assign n_ex  = $signed({i_ax_start[W-1], i_ax_start}) - $signed({i_bx_start[W-1], i_bx_start});
    assign n_ey  = $signed({i_ay_start[W-1], i_ay_start}) - $signed({i_by_start[W-1], i_by_start});
    assign n_msum = $signed({i_ax_start[W-1], i_ax_start}) + $signed({i_ax_end[W-1], i_ax_end});

    // The midpoint keeps the sign bit of the widened sum, so the shift floors.
    always_comb begin
        logic signed [DW-1:0] ysum;
        ysum = $signed({i_ay_start[W-1], i_ay_start}) + $signed({i_ay_end[W-1], i_ay_end});
        n_pass = {ysum[DW-1:1], n_msum[DW-1:1], i_ay_start, i_ax_start};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx1   <= n_dx1;
        r_dy1   <= n_dy1;
        r_dx2   <= n_dx2;
        r_dy2   <= n_dy2;
        r_ex    <= n_ex;
        r_ey    <= n_ey;
        r1_pass <= n_pass;

        r_pd1   <= PW'(r_dy2) * PW'(r_dx1);
        r_pd2   <= PW'(r_dx2) * PW'(r_dy1);
        r_pa1   <= PW'(r_dx2) * PW'(r_ey);
        r_pa2   <= PW'(r_dy2) * PW'(r_ex);
        r_pb1   <= PW'(r_dx1) * PW'(r_ey);
        r_pb2   <= PW'(r_dy1) * PW'(r_ex);
        r2_dx1  <= r_dx1;
        r2_dy1  <= r_dy1;
        r2_pass <= r1_pass;

        r_den   <= $signed({r_pd1[PW-1], r_pd1}) - $signed({r_pd2[PW-1], r_pd2});
        r_na    <= $signed({r_pa1[PW-1], r_pa1}) - $signed({r_pa2[PW-1], r_pa2});
        r_nb    <= $signed({r_pb1[PW-1], r_pb1}) - $signed({r_pb2[PW-1], r_pb2});
        r3_dx1  <= r2_dx1;
        r3_dy1  <= r2_dy1;
        r3_pass <= r2_pass;
    end

    assign o_valid = r_valid[2];
    assign o_den   = r_den;
    assign o_na    = r_na;
    assign o_nb    = r_nb;
    assign o_dx1   = r3_dx1;
    assign o_dy1   = r3_dy1;
    assign o_pass  = r3_pass;

endmodule
`default_nettype wire

### src/segx_decide.sv
`default_nettype none
module segx_decide #(
    parameter int COORD_WIDTH = segx_pkg::COORD_WIDTH_DEF,
    localparam int DW = COORD_WIDTH + 1,
    localparam int CW = 2 * DW + 1,
    localparam int PD = CW + COORD_WIDTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    input  wire logic signed [CW-1:0]            i_den,
    input  wire logic signed [CW-1:0]            i_na,
    input  wire logic signed [CW-1:0]            i_nb,
    input  wire logic signed [DW-1:0]            i_dx1,
    input  wire logic signed [DW-1:0]            i_dy1,
    input  wire logic [4*COORD_WIDTH-1:0]        i_pass,
    input  wire logic [segx_pkg::TOL_WIDTH-1:0]  i_tol,
    output segx_pkg::t_ctrl                      o_ctrl,
    output logic [CW-1:0]                        o_den_mag,
    output logic [PD-1:0]                        o_prod_x,
    output logic [PD-1:0]                        o_prod_y,
    output logic [4*COORD_WIDTH-1:0]             o_pass
);
    import segx_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int LO = (CW + 1) / 2;
    localparam int HI = CW - LO;
    localparam int MW = (CW > TOL_WIDTH) ? CW : TOL_WIDTH;

    logic [CW-1:0] n_den_mag, n_na_mag, n_nb_mag;
    logic [DW-1:0] n_dx_abs, n_dy_abs;

    logic                 r4_valid;
    logic [CW-1:0]        r4_den_mag, r4_na_mag, r4_nb_mag;
    logic                 r4_s_den, r4_s_na, r4_s_nb, r4_s_dx, r4_s_dy;
    logic                 r4_z_na, r4_z_nb;
    logic [W-1:0]         r4_dx_mag, r4_dy_mag;
    logic [4*W-1:0]       r4_pass;

    logic [TOL_WIDTH-1:0] n_tol;
    logic                 n_nz_den, n_nz_na, n_nz_nb, n_unit_a, n_unit_b;
    t_ctrl                n_ctrl;

    t_ctrl                r5_ctrl, r6_ctrl;
    logic [CW-1:0]        r5_den_mag, r6_den_mag;
    logic [LO+W-1:0]      r5_pxl, r5_pyl;
    logic [HI+W-1:0]      r5_pxh, r5_pyh;
    logic [4*W-1:0]       r5_pass, r6_pass;
    logic [PD-1:0]        r6_prod_x, r6_prod_y;

    assign n_den_mag = i_den[CW-1] ? $unsigned(-i_den) : $unsigned(i_den);
    assign n_na_mag  = i_na[CW-1]  ? $unsigned(-i_na)  : $unsigned(i_na);
    assign n_nb_mag  = i_nb[CW-1]  ? $unsigned(-i_nb)  : $unsigned(i_nb);
    assign n_dx_abs  = i_dx1[DW-1] ? $unsigned(-i_dx1) : $unsigned(i_dx1);
    assign n_dy_abs  = i_dy1[DW-1] ? $unsigned(-i_dy1) : $unsigned(i_dy1);

    assign n_tol    = (i_tol == '0) ? TOL_WIDTH'(1) : i_tol;
    assign n_nz_den = MW'(r4_den_mag) < MW'(n_tol);
    assign n_nz_na  = MW'(r4_na_mag) < MW'(n_tol);
    assign n_nz_nb  = MW'(r4_nb_mag) < MW'(n_tol);
    assign n_unit_a = r4_z_na || ((r4_s_na == r4_s_den) && (r4_na_mag <= r4_den_mag));
    assign n_unit_b = r4_z_nb || ((r4_s_nb == r4_s_den) && (r4_nb_mag <= r4_den_mag));

    always_comb begin
        n_ctrl.valid = r4_valid;
        n_ctrl.neg_x = r4_s_na ^ r4_s_dx ^ r4_s_den;
        n_ctrl.neg_y = r4_s_na ^ r4_s_dy ^ r4_s_den;
        if (n_nz_den && n_nz_na && n_nz_nb) begin
            n_ctrl.status = ST_OVERLAP;
        end else if (!n_nz_den && n_unit_a && n_unit_b) begin
            n_ctrl.status = ST_CROSS;
        end else begin
            n_ctrl.status = ST_MISS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
            r5_ctrl  <= CTRL_IDLE;
            r6_ctrl  <= CTRL_IDLE;
        end else begin
            r4_valid <= i_valid;
            r5_ctrl  <= n_ctrl;
            r6_ctrl  <= r5_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_den_mag <= n_den_mag;
        r4_na_mag  <= n_na_mag;
        r4_nb_mag  <= n_nb_mag;
        r4_s_den   <= i_den[CW-1];
        r4_s_na    <= i_na[CW-1];
        r4_s_nb    <= i_nb[CW-1];
        r4_s_dx    <= i_dx1[DW-1];
        r4_s_dy    <= i_dy1[DW-1];
        r4_z_na    <= (i_na == '0);
        r4_z_nb    <= (i_nb == '0);
        r4_dx_mag  <= n_dx_abs[W-1:0];
        r4_dy_mag  <= n_dy_abs[W-1:0];
        r4_pass    <= i_pass;

        r5_den_mag <= r4_den_mag;
        r5_pxl     <= (LO+W)'(r4_na_mag[LO-1:0]) * (LO+W)'(r4_dx_mag);
        r5_pyl     <= (LO+W)'(r4_na_mag[LO-1:0]) * (LO+W)'(r4_dy_mag);
        r5_pxh     <= (HI+W)'(r4_na_mag[CW-1:LO]) * (HI+W)'(r4_dx_mag);
        r5_pyh     <= (HI+W)'(r4_na_mag[CW-1:LO]) * (HI+W)'(r4_dy_mag);
        r5_pass    <= r4_pass;

        r6_den_mag <= r5_den_mag;
        r6_prod_x  <= PD'(r5_pxl) + (PD'(r5_pxh) << LO);
        r6_prod_y  <= PD'(r5_pyl) + (PD'(r5_pyh) << LO);
        r6_pass    <= r5_pass;
    end

    assign o_ctrl    = r6_ctrl;
    assign o_den_mag = r6_den_mag;
    assign o_prod_x  = r6_prod_x;
    assign o_prod_y  = r6_prod_y;
    assign o_pass    = r6_pass;

endmodule
`default_nettype wire

### src/segx_div_step.sv
`default_nettype none
module segx_div_step #(
    parameter int COORD_WIDTH = segx_pkg::COORD_WIDTH_DEF,
    parameter int STEP_BIT = 0,
    localparam int CW = 2 * COORD_WIDTH + 3,
    localparam int PD = CW + COORD_WIDTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  segx_pkg::t_ctrl               i_ctrl,
    input  wire logic [CW-1:0]            i_den_mag,
    input  wire logic [PD-1:0]            i_rem_x,
    input  wire logic [PD-1:0]            i_rem_y,
    input  wire logic [COORD_WIDTH-1:0]   i_quo_x,
    input  wire logic [COORD_WIDTH-1:0]   i_quo_y,
    input  wire logic [4*COORD_WIDTH-1:0] i_pass,
    output segx_pkg::t_ctrl               o_ctrl,
    output logic [CW-1:0]                 o_den_mag,
    output logic [PD-1:0]                 o_rem_x,
    output logic [PD-1:0]                 o_rem_y,
    output logic [COORD_WIDTH-1:0]        o_quo_x,
    output logic [COORD_WIDTH-1:0]        o_quo_y,
    output logic [4*COORD_WIDTH-1:0]      o_pass
);
    import segx_pkg::*;

    logic [PD-1:0]          n_dsh;
    logic                   n_ge_x, n_ge_y;
    t_ctrl                  r_ctrl;
    logic [CW-1:0]          r_den_mag;
    logic [PD-1:0]          r_rem_x, r_rem_y;
    logic [COORD_WIDTH-1:0] r_quo_x, r_quo_y;
    logic [4*COORD_WIDTH-1:0] r_pass;

    assign n_dsh  = PD'(i_den_mag) << STEP_BIT;
    assign n_ge_x = i_rem_x >= n_dsh;
    assign n_ge_y = i_rem_y >= n_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= CTRL_IDLE;
        end else begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_den_mag <= i_den_mag;
        r_pass    <= i_pass;
        r_rem_x   <= n_ge_x ? (i_rem_x - n_dsh) : i_rem_x;
        r_rem_y   <= n_ge_y ? (i_rem_y - n_dsh) : i_rem_y;
        r_quo_x   <= i_quo_x | (COORD_WIDTH'(n_ge_x) << STEP_BIT);
        r_quo_y   <= i_quo_y | (COORD_WIDTH'(n_ge_y) << STEP_BIT);
    end

    assign o_ctrl    = r_ctrl;
    assign o_den_mag = r_den_mag;
    assign o_rem_x   = r_rem_x;
    assign o_rem_y   = r_rem_y;
    assign o_quo_x   = r_quo_x;
    assign o_quo_y   = r_quo_y;
    assign o_pass    = r_pass;

endmodule
`default_nettype wire
